### rtl/binary_grid_segment_detector_macros.svh
// assertion macros for the binary grid segment detector
// used by rtl/binary_grid_segment_detector.sv, no other dependencies
`ifndef BINARY_GRID_SEGMENT_DETECTOR_MACROS_SVH
`define BINARY_GRID_SEGMENT_DETECTOR_MACROS_SVH

`ifndef SYNTHESIS
`define BGSD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BGSD_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BGSD_ASSERT(label, clk, rst, prop, msg)
`define BGSD_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### rtl/bgsd_pkg.sv
// types and constants of the binary grid segment detector
// no dependencies; used by bgsd_result_fifo and the top level
`timescale 1ns / 1ps

package bgsd_pkg;

   localparam int GRID_SIZE_DEFAULT = 16;
   localparam int COORD_W           = 4;
   localparam int RUN_W             = 5;
   localparam logic [RUN_W-1:0] RUN_MAX       = 5'd31;
   localparam logic [RUN_W-1:0] MIN_RUN_RESET = 5'd2;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef struct packed {
      logic pixel;
      logic frame_start;
   } req_type;

   typedef struct packed {
      logic               is_vertical;
      logic [COORD_W-1:0] start_row;
      logic [COORD_W-1:0] start_col;
      logic [COORD_W-1:0] end_row;
      logic [COORD_W-1:0] end_col;
      logic               last_of_item;
   } rsp_type;

   typedef struct packed {
      logic push_first;
      logic push_second;
   } fifo_push_type;

endpackage

### rtl/bgsd_result_fifo.sv
// four-entry segment queue that takes up to two segments per cycle
// depends on bgsd_pkg
`timescale 1ns / 1ps

module bgsd_result_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  bgsd_pkg::fifo_push_type push,
   input  bgsd_pkg::rsp_type       first_data,
   input  bgsd_pkg::rsp_type       second_data,
   output logic                    has_room,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output bgsd_pkg::rsp_type       rsp_data
);

   bgsd_pkg::rsp_type                  fifo_ff [bgsd_pkg::RSP_DEPTH];
   logic [bgsd_pkg::RSP_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [bgsd_pkg::RSP_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [bgsd_pkg::RSP_CNT_W-1:0]     count_ff, count_in;
   logic                               pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign has_room  = (count_ff <= bgsd_pkg::RSP_CNT_W'(bgsd_pkg::RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + bgsd_pkg::RSP_PTR_W'(push.push_first)
                            + bgsd_pkg::RSP_PTR_W'(push.push_second);
      rd_ptr_in = rd_ptr_ff + bgsd_pkg::RSP_PTR_W'(pop);
      count_in  = count_ff + bgsd_pkg::RSP_CNT_W'(push.push_first)
                           + bgsd_pkg::RSP_CNT_W'(push.push_second)
                           - bgsd_pkg::RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.push_first) begin
         fifo_ff[wr_ptr_ff] <= first_data;
      end
      if (push.push_second) begin
         fifo_ff[wr_ptr_ff + bgsd_pkg::RSP_PTR_W'(1)] <= second_data;
      end
   end

endmodule

### rtl/binary_grid_segment_detector.sv
// binary grid segment detector: top level with raster tracking and column memory
// depends on bgsd_pkg, bgsd_result_fifo and binary_grid_segment_detector_macros.svh
//
// Pixels of a square binary image enter on the req_ channel in raster order,
// one per request; frame_start on a request marks pixel (0,0) of a new image.
// Every run of ones that ends (at a zero or at the image edge) and holds at
// least min_run_length pixels leaves as one segment on the rsp_ channel,
// horizontal before vertical when one pixel ends both; last_of_item marks
// the final segment caused by a pixel. csr_wr_en writes min_run_length.
// A request is taken in any cycle in which req_stall is low: one pixel per
// cycle. Its segments pass the pixel stage and the result queue to rsp_. A pixel
// ending two runs makes two segments, and the one-segment-per-cycle response
// side, while rsp_stall is low, then sets the sustained rate. Segments wait in a
// four-entry queue; req_stall rises while it holds over two and the pixel stage
// is occupied. Per-column run state sits in a GRID_SIZE-entry memory read when a
// request is taken and written as the pixel stage advances, with one valid flag
// per column. Reset empties the pipeline and queue, clears all run state and sets
// min_run_length to 2; frame_start drops runs left open by a cut frame.
`timescale 1ns / 1ps

`include "binary_grid_segment_detector_macros.svh"

module binary_grid_segment_detector #(
   parameter int GRID_SIZE = bgsd_pkg::GRID_SIZE_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  bgsd_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output bgsd_pkg::rsp_type            rsp_data,
   input  logic                         csr_wr_en,
   input  logic [bgsd_pkg::RUN_W-1:0]   csr_wr_data
);

   localparam int CW = $clog2(GRID_SIZE);
   localparam int XW = (CW > bgsd_pkg::COORD_W) ? CW : bgsd_pkg::COORD_W;
   localparam logic [CW-1:0] LAST = CW'(GRID_SIZE - 1);

   function automatic logic [bgsd_pkg::COORD_W-1:0] to_coord(input logic [CW-1:0] v);
      logic [XW-1:0] w;
      w = XW'(v);
      return w[bgsd_pkg::COORD_W-1:0];
   endfunction

   // configuration
   logic [bgsd_pkg::RUN_W-1:0]   min_run_ff;
   logic [bgsd_pkg::RUN_W-1:0]   min_eff;

   // raster position of the next request
   logic [CW-1:0]                pos_row_ff, pos_row_in;
   logic [CW-1:0]                pos_col_ff, pos_col_in;
   logic [CW-1:0]                item_row, item_col;

   // pixel stage
   logic                         s1_vld_ff;
   logic                         s1_pixel_ff;
   logic                         s1_fs_ff;
   logic [CW-1:0]                s1_row_ff;
   logic [CW-1:0]                s1_col_ff;
   logic [bgsd_pkg::RUN_W-1:0]   rd_len_ff;
   logic [CW-1:0]                rd_start_ff;
   logic                         rd_vld_ff;

   // horizontal run
   logic [bgsd_pkg::RUN_W-1:0]   row_len_ff, row_len_in;
   logic [CW-1:0]                row_start_ff, row_start_in;

   // column memory
   logic [bgsd_pkg::RUN_W-1:0]   col_len_mem   [GRID_SIZE];
   logic [CW-1:0]                col_start_mem [GRID_SIZE];
   logic [GRID_SIZE-1:0]         col_vld_ff;
   logic [CW-1:0]                rd_addr;
   logic [bgsd_pkg::RUN_W-1:0]   col_len_in;
   logic [CW-1:0]                col_start_in;

   // segment logic
   logic [bgsd_pkg::RUN_W-1:0]   h_len, v_len, h_inc, v_inc;
   logic [CW-1:0]                h_start, v_start, h_end_col, v_end_row;
   logic                         emit_h, emit_v;
   bgsd_pkg::rsp_type            h_seg, v_seg;
   bgsd_pkg::rsp_type            first_seg;
   bgsd_pkg::fifo_push_type      push;

   logic                         accept;
   logic                         advance;
   logic                         has_room;

   assign advance   = s1_vld_ff && has_room;
   assign req_stall = s1_vld_ff && !has_room;
   assign accept    = req_valid && !req_stall;
   assign min_eff   = (min_run_ff == '0) ? bgsd_pkg::RUN_W'(1) : min_run_ff;

   // position tracking at request time
   always_comb begin
      item_row = req_data.frame_start ? '0 : pos_row_ff;
      item_col = req_data.frame_start ? '0 : pos_col_ff;
      rd_addr  = item_col;
      if (item_col == LAST) begin
         pos_col_in = '0;
         pos_row_in = (item_row == LAST) ? '0 : item_row + CW'(1);
      end else begin
         pos_col_in = item_col + CW'(1);
         pos_row_in = item_row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= bgsd_pkg::MIN_RUN_RESET;
         pos_row_ff <= '0;
         pos_col_ff <= '0;
         s1_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_run_ff <= csr_wr_data;
         end
         if (accept) begin
            pos_row_ff <= pos_row_in;
            pos_col_ff <= pos_col_in;
            s1_vld_ff  <= 1'b1;
         end else if (advance) begin
            s1_vld_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff <= req_data.pixel;
         s1_fs_ff    <= req_data.frame_start;
         s1_row_ff   <= item_row;
         s1_col_ff   <= item_col;
         rd_len_ff   <= col_len_mem[rd_addr];
         rd_start_ff <= col_start_mem[rd_addr];
         rd_vld_ff   <= col_vld_ff[rd_addr] && !req_data.frame_start;
      end
   end

   // run updates and segment formation
   always_comb begin
      h_len   = s1_fs_ff ? '0 : row_len_ff;
      h_start = (s1_fs_ff || h_len == '0) ? s1_col_ff : row_start_ff;
      h_inc   = (h_len == bgsd_pkg::RUN_MAX) ? h_len : h_len + bgsd_pkg::RUN_W'(1);
      v_len   = rd_vld_ff ? rd_len_ff : '0;
      v_start = (v_len == '0) ? s1_row_ff : rd_start_ff;
      v_inc   = (v_len == bgsd_pkg::RUN_MAX) ? v_len : v_len + bgsd_pkg::RUN_W'(1);

      row_start_in = h_start;
      col_start_in = v_start;
      h_end_col    = s1_col_ff;
      v_end_row    = s1_row_ff;

      if (s1_pixel_ff) begin
         if (s1_col_ff == LAST) begin
            emit_h     = (h_inc >= min_eff);
            row_len_in = '0;
         end else begin
            emit_h     = 1'b0;
            row_len_in = h_inc;
         end
         if (s1_row_ff == LAST) begin
            emit_v     = (v_inc >= min_eff);
            col_len_in = '0;
         end else begin
            emit_v     = 1'b0;
            col_len_in = v_inc;
         end
      end else begin
         emit_h     = (h_len >= min_eff);
         emit_v     = (v_len >= min_eff);
         row_len_in = '0;
         col_len_in = '0;
         h_end_col  = s1_col_ff - CW'(1);
         v_end_row  = s1_row_ff - CW'(1);
      end

      h_seg.is_vertical  = 1'b0;
      h_seg.start_row    = to_coord(s1_row_ff);
      h_seg.start_col    = to_coord(h_start);
      h_seg.end_row      = to_coord(s1_row_ff);
      h_seg.end_col      = to_coord(h_end_col);
      h_seg.last_of_item = !emit_v;

      v_seg.is_vertical  = 1'b1;
      v_seg.start_row    = to_coord(v_start);
      v_seg.start_col    = to_coord(s1_col_ff);
      v_seg.end_row      = to_coord(v_end_row);
      v_seg.end_col      = to_coord(s1_col_ff);
      v_seg.last_of_item = 1'b1;

      first_seg        = emit_h ? h_seg : v_seg;
      push.push_first  = advance && (emit_h || emit_v);
      push.push_second = advance && emit_h && emit_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff   <= '0;
         row_start_ff <= '0;
         col_vld_ff   <= '0;
      end else begin
         if (advance) begin
            row_len_ff   <= row_len_in;
            row_start_ff <= row_start_in;
         end
         // new frame drops all column runs, including the one written back now
         if (accept && req_data.frame_start) begin
            col_vld_ff <= '0;
         end else if (advance) begin
            col_vld_ff[s1_col_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         col_len_mem[s1_col_ff]   <= col_len_in;
         col_start_mem[s1_col_ff] <= col_start_in;
      end
   end

   bgsd_result_fifo u_result_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_data  (first_seg),
      .second_data (v_seg),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `BGSD_ASSERT(a_frame_clears_cols, clock, reset, (accept && req_data.frame_start) |=> (col_vld_ff == '0), "frame start left a column run open")
   `BGSD_ASSERT(a_row_ends_at_edge, clock, reset, (advance && s1_col_ff == LAST) |=> (row_len_ff == '0), "horizontal run carried past the last column")
   `BGSD_ASSERT_NEVER(a_pos_in_grid, clock, reset, s1_vld_ff && (s1_row_ff > LAST || s1_col_ff > LAST), "pixel position outside the grid")

endmodule

### dv/tb.sv
// self-checking testbench for binary_grid_segment_detector
// holds a segment predictor class and the drivers for the req_, rsp_ and csr_ ports
// depends on bgsd_pkg and the rtl top level
`timescale 1ns / 1ps

module tb;

   localparam int GRID         = bgsd_pkg::GRID_SIZE_DEFAULT;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES  = 60;
   localparam int LIMIT_NS     = 2000000;

   class segment_predictor;
      logic [bgsd_pkg::RUN_W-1:0]   min_len;
      logic [bgsd_pkg::COORD_W-1:0] row;
      logic [bgsd_pkg::COORD_W-1:0] col;
      logic [bgsd_pkg::RUN_W-1:0]   hrun_len;
      logic [bgsd_pkg::COORD_W-1:0] hrun_start;
      logic [bgsd_pkg::RUN_W-1:0]   vrun_len[GRID];
      logic [bgsd_pkg::COORD_W-1:0] vrun_start[GRID];
      bgsd_pkg::rsp_type            expected_segments[$];
      int                           errors;
      int                           seen_pixels;
      int                           seen_segments;

      function new();
         min_len = bgsd_pkg::MIN_RUN_RESET;
         errors = 0;
         seen_pixels = 0;
         seen_segments = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         row = '0;
         col = '0;
         hrun_len = '0;
         hrun_start = '0;
         for (int i = 0; i < GRID; i++) begin
            vrun_len[i] = '0;
            vrun_start[i] = '0;
         end
      endfunction

      function void set_min(logic [bgsd_pkg::RUN_W-1:0] value);
         min_len = value;
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      function bit long_enough(logic [bgsd_pkg::RUN_W-1:0] len);
         logic [bgsd_pkg::RUN_W-1:0] m;
         m = (min_len == '0) ? 5'd1 : min_len;
         return len >= m;
      endfunction

      function bgsd_pkg::rsp_type make_segment(logic vert,
                                               logic [bgsd_pkg::COORD_W-1:0] sr,
                                               logic [bgsd_pkg::COORD_W-1:0] sc,
                                               logic [bgsd_pkg::COORD_W-1:0] er,
                                               logic [bgsd_pkg::COORD_W-1:0] ec);
         bgsd_pkg::rsp_type s;
         s.is_vertical = vert;
         s.start_row = sr;
         s.start_col = sc;
         s.end_row = er;
         s.end_col = ec;
         s.last_of_item = 1'b0;
         return s;
      endfunction

      function void note_pixel(bgsd_pkg::req_type item);
         bgsd_pkg::rsp_type            found[2];
         int                           n;
         logic [bgsd_pkg::COORD_W-1:0] r;
         logic [bgsd_pkg::COORD_W-1:0] c;
         n = 0;
         seen_pixels++;
         if (item.frame_start) clear_frame();
         r = row;
         c = col;
         // horizontal run
         if (item.pixel) begin
            if (hrun_len == '0) hrun_start = c;
            if (hrun_len < bgsd_pkg::RUN_MAX) hrun_len = hrun_len + 1'b1;
            if (c == GRID - 1) begin
               if (long_enough(hrun_len)) begin
                  found[n] = make_segment(1'b0, r, hrun_start, r, c);
                  n++;
               end
               hrun_len = '0;
            end
         end else begin
            if (hrun_len != '0 && long_enough(hrun_len)) begin
               found[n] = make_segment(1'b0, r, hrun_start, r, c - 1'b1);
               n++;
            end
            hrun_len = '0;
         end
         // vertical run of this column
         if (item.pixel) begin
            if (vrun_len[c] == '0) vrun_start[c] = r;
            if (vrun_len[c] < bgsd_pkg::RUN_MAX) vrun_len[c] = vrun_len[c] + 1'b1;
            if (r == GRID - 1) begin
               if (long_enough(vrun_len[c])) begin
                  found[n] = make_segment(1'b1, vrun_start[c], c, r, c);
                  n++;
               end
               vrun_len[c] = '0;
            end
         end else begin
            if (vrun_len[c] != '0 && long_enough(vrun_len[c])) begin
               found[n] = make_segment(1'b1, vrun_start[c], c, r - 1'b1, c);
               n++;
            end
            vrun_len[c] = '0;
         end
         if (n > 0) found[n-1].last_of_item = 1'b1;
         for (int i = 0; i < n; i++) expected_segments.push_back(found[i]);
         if (c == GRID - 1) begin
            col = '0;
            row = (r == GRID - 1) ? '0 : r + 1'b1;
         end else begin
            col = c + 1'b1;
         end
      endfunction

      function void check_segment(bgsd_pkg::rsp_type got);
         bgsd_pkg::rsp_type want;
         seen_segments++;
         if (expected_segments.size() == 0) begin
            $error("segment with nothing expected: %p", got);
            errors++;
            return;
         end
         want = expected_segments.pop_front();
         if (got.is_vertical !== want.is_vertical) begin
            $error("is_vertical expected %0d got %0d", want.is_vertical, got.is_vertical);
            errors++;
         end
         if (got.start_row !== want.start_row) begin
            $error("start_row expected %0d got %0d", want.start_row, got.start_row);
            errors++;
         end
         if (got.start_col !== want.start_col) begin
            $error("start_col expected %0d got %0d", want.start_col, got.start_col);
            errors++;
         end
         if (got.end_row !== want.end_row) begin
            $error("end_row expected %0d got %0d", want.end_row, got.end_row);
            errors++;
         end
         if (got.end_col !== want.end_col) begin
            $error("end_col expected %0d got %0d", want.end_col, got.end_col);
            errors++;
         end
         if (got.last_of_item !== want.last_of_item) begin
            $error("last_of_item expected %0d got %0d", want.last_of_item, got.last_of_item);
            errors++;
         end
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   bgsd_pkg::req_type          req_data = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   bgsd_pkg::rsp_type          rsp_data;
   logic                       csr_wr_en = 1'b0;
   logic [bgsd_pkg::RUN_W-1:0] csr_wr_data = '0;

   segment_predictor sb = new();
   int               send_idle_pct = 0;
   int               recv_idle_pct = 0;
   bit               hold_off = 1'b0;

   binary_grid_segment_detector #(
      .GRID_SIZE(GRID)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_pixel(req_data);
         if (rsp_valid && !rsp_stall) sb.check_segment(rsp_data);
      end
   end

   // receiver: random stall, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("Mismatches found");
      $finish;
   end

   // called at a rising edge, returns at the edge where the request is taken
   task automatic send_pixel(bit px, bit fs);
      bgsd_pkg::req_type item;
      item.pixel = px;
      item.frame_start = fs;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_frame(int style, int density, bit use_fs, int length);
      logic [GRID-1:0] row_mask;
      logic [GRID-1:0] col_mask;
      int              r;
      int              c;
      bit              px;
      for (int i = 0; i < GRID; i++) begin
         row_mask[i] = ($urandom_range(99) < density);
         col_mask[i] = ($urandom_range(99) < density);
      end
      for (int idx = 0; idx < length; idx++) begin
         r = idx / GRID;
         c = idx % GRID;
         case (style)
            0: px = ($urandom_range(99) < density);
            1: px = row_mask[r];
            2: px = col_mask[c];
            default: px = row_mask[r] | col_mask[c];
         endcase
         send_pixel(px, use_fs && idx == 0);
      end
   endtask

   task automatic run_phase(logic [bgsd_pkg::RUN_W-1:0] min_len, int s_idle, int r_idle,
                            int n_items, bit with_pressure);
      int sent;
      int style;
      int density;
      int length;
      bit use_fs;
      bit prev_full;
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= min_len;
      @(posedge clock);
      sb.set_min(min_len);
      csr_wr_en <= 1'b0;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sent = 0;
      prev_full = 1'b0;
      while (sent < n_items) begin
         style = $urandom_range(3);
         case ($urandom_range(4))
            0: density = 0;
            1: density = 15;
            2: density = 50;
            3: density = 85;
            default: density = 100;
         endcase
         length = ($urandom_range(99) < 15) ? $urandom_range(1, GRID * GRID - 1) : GRID * GRID;
         use_fs = !(prev_full && $urandom_range(99) < 10);
         if (with_pressure && sent == 0) begin
            // dense noisy frame while the receiver holds off
            style = 0;
            density = 50;
            length = GRID * GRID;
            hold_off = 1'b1;
         end
         if (length > n_items - sent) length = n_items - sent;
         send_frame(style, density, use_fs, length);
         sent += length;
         prev_full = (length == GRID * GRID);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short runs, a cut frame, a full row reaching the edge
      send_pixel(1'b1, 1'b1);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b0);
      send_pixel(1'b1, 1'b1);
      repeat (GRID - 1) send_pixel(1'b1, 1'b0);
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b0);

      run_phase(5'd0, 22, 65, 500, 1'b0);
      run_phase(5'd16, 65, 22, 500, 1'b0);
      run_phase(5'd1, 0, 0, 450, 1'b1);
      run_phase(5'd31, 0, 0, 260, 1'b0);
      run_phase(5'd3, 0, 0, 250, 1'b0);

      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d pixel requests and %0d segments", sb.seen_pixels,
               sb.seen_segments);
      $display("thresholds 2, 0, 16, 1, 31 and 3, with cut and wrapped frames");
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
